### sv/tga_rle_pixel_decoder_core_assert.svh
// assertion macros for the tga rle pixel decoder core
`ifndef TGA_RLE_PIXEL_DECODER_CORE_ASSERT_SVH
`define TGA_RLE_PIXEL_DECODER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define TGARLE_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tgarle check failed");
`define TGARLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tgarle check failed");
`else
`define TGARLE_ASSERT_SAME(label, clk, rst, ante, cons)
`define TGARLE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### sv/tgarle_pkg.sv
// shared types, codes and helpers for the tga rle pixel decoder
package tgarle_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_RLE_MODE    = 2'd0;
  localparam logic [1:0] REG_PIXEL_BYTES = 2'd1;
  localparam logic [1:0] REG_PIXEL_TOTAL = 2'd2;

  localparam int unsigned CfgDataWidth = 32;

  localparam logic        RLE_MODE_RESET    = 1'b1;
  localparam logic [2:0]  PIXEL_BYTES_RESET = 3'd4;
  localparam logic [31:0] PIXEL_TOTAL_RESET = 32'd1;

  localparam logic [2:0] BPP_MIN = 3'd2;
  localparam logic [2:0] BPP_MID = 3'd3;
  localparam logic [2:0] BPP_MAX = 3'd4;

  localparam int unsigned RunFlagBit = 7;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EARLY_END = 2'd1,
    STATUS_OVERRUN   = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  typedef struct packed {
    pixel_t     pix;
    logic [7:0] repeat_count;
    logic       final_pixel;
    status_t    status;
    logic       image_opaque;
    logic       image_one_bit_alpha;
  } result_t;

  // 5-bit channel to 8 bits by replicating the top bits
  function automatic logic [7:0] widen5(input logic [4:0] v);
    widen5 = {v, v[4:2]};
  endfunction

endpackage

### sv/tgarle_pixel_unpack.sv
// assembles one rgba pixel from the stored bytes and the closing byte
module tgarle_pixel_unpack (
  input  logic [2:0]           bpp,
  input  logic [23:0]          partial,
  input  logic [7:0]           last_byte,
  output tgarle_pkg::pixel_t   pix
);

  logic [15:0] word16;

  assign word16 = {last_byte, partial[7:0]};

  always_comb begin
    pix = '0;
    if (bpp == tgarle_pkg::BPP_MIN) begin
      // 5-5-5 little-endian, top bit unused
      pix.red   = tgarle_pkg::widen5(word16[14:10]);
      pix.green = tgarle_pkg::widen5(word16[9:5]);
      pix.blue  = tgarle_pkg::widen5(word16[4:0]);
      pix.alpha = tgarle_pkg::ALPHA_OPAQUE;
    end else if (bpp == tgarle_pkg::BPP_MID) begin
      pix.blue  = partial[7:0];
      pix.green = partial[15:8];
      pix.red   = last_byte;
      pix.alpha = tgarle_pkg::ALPHA_OPAQUE;
    end else begin
      pix.blue  = partial[7:0];
      pix.green = partial[15:8];
      pix.red   = partial[23:16];
      pix.alpha = last_byte;
    end
  end

endmodule

### sv/tga_rle_pixel_decoder_core.sv
// tga pixel data decoder (raw and run-length), one byte per transfer
// a result is registered in the output register, visible the cycle after its byte is taken
// one byte per cycle if not stalled; path set by the 32-bit pixel count add and compare
// the input is taken whenever the output register is empty or being drained
// rst (synchronous) clears control state and restores the register defaults:
// run-length mode, 4 bytes per pixel, one pixel in the image
module tga_rle_pixel_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  input  logic        s_axis_tlast,   // end_of_file
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // red[7:0], green[15:8], blue[23:16], alpha[31:24], repeat_count[39:32]
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast,   // final_pixel
  // status[1:0], image_opaque[2], image_one_bit_alpha[3]
  output logic [3:0]  m_axis_tuser,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [tgarle_pkg::CfgDataWidth-1:0] cfg_data
);

  `include "tga_rle_pixel_decoder_core_assert.svh"

  // configuration
  logic        rle_mode, rle_mode_next;
  logic [2:0]  pixel_bytes_count, pixel_bytes_count_next;
  logic [31:0] pixel_total, pixel_total_next;

  // decoder state
  logic        expect_hdr, expect_hdr_next;
  logic        is_run, is_run_next;
  logic [7:0]  pixels_left, pixels_left_next;
  logic [1:0]  byte_pos, byte_pos_next;
  logic [23:0] partial, partial_next;
  logic [31:0] pixels_done, pixels_done_next;
  logic        failed, failed_next;
  logic        opaque, opaque_next;
  logic        binary_alpha, binary_alpha_next;

  // output register
  logic                out_valid;
  tgarle_pkg::result_t out_res;
  tgarle_pkg::result_t res;
  logic                res_valid;

  logic        in_fire;
  logic        active;
  logic [2:0]  bpp;
  logic [7:0]  hdr_len;
  logic [32:0] hdr_sum;
  logic [31:0] shifted;
  logic [7:0]  count;
  logic [32:0] done_sum;
  logic        done_now;
  tgarle_pkg::pixel_t pix;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (pixel_bytes_count < tgarle_pkg::BPP_MIN) begin
      bpp = tgarle_pkg::BPP_MIN;
    end else if (pixel_bytes_count > tgarle_pkg::BPP_MAX) begin
      bpp = tgarle_pkg::BPP_MAX;
    end else begin
      bpp = pixel_bytes_count;
    end
  end

  tgarle_pixel_unpack u_unpack (
    .bpp       (bpp),
    .partial   (partial),
    .last_byte (s_axis_tdata),
    .pix       (pix)
  );

  assign active  = !failed && (pixels_done < pixel_total);
  assign hdr_len = {1'b0, s_axis_tdata[6:0]} + 8'd1;
  assign hdr_sum = {1'b0, pixels_done} + {25'd0, hdr_len};
  assign shifted = {24'd0, s_axis_tdata} << {byte_pos, 3'b000};

  always_comb begin
    if (!rle_mode) begin
      count = 8'd1;
    end else if (is_run) begin
      count = (pixels_left == 8'd0) ? 8'd1 : pixels_left;
    end else begin
      count = 8'd1;
    end
  end

  assign done_sum = {1'b0, pixels_done} + {25'd0, count};
  assign done_now = done_sum >= {1'b0, pixel_total};

  always_comb begin
    rle_mode_next          = rle_mode;
    pixel_bytes_count_next = pixel_bytes_count;
    pixel_total_next       = pixel_total;
    expect_hdr_next        = expect_hdr;
    is_run_next            = is_run;
    pixels_left_next       = pixels_left;
    byte_pos_next          = byte_pos;
    partial_next           = partial;
    pixels_done_next       = pixels_done;
    failed_next            = failed;
    opaque_next            = opaque;
    binary_alpha_next      = binary_alpha;
    res_valid              = 1'b0;
    res                    = '0;
    res.status             = tgarle_pkg::STATUS_OK;

    if (in_fire && active) begin
      if (rle_mode && expect_hdr) begin
        if (s_axis_tlast) begin
          failed_next     = 1'b1;
          res_valid       = 1'b1;
          res.final_pixel = 1'b1;
          res.status      = tgarle_pkg::STATUS_EARLY_END;
        end else if (hdr_sum > {1'b0, pixel_total}) begin
          failed_next     = 1'b1;
          res_valid       = 1'b1;
          res.final_pixel = 1'b1;
          res.status      = tgarle_pkg::STATUS_OVERRUN;
        end else begin
          is_run_next      = s_axis_tdata[tgarle_pkg::RunFlagBit];
          pixels_left_next = hdr_len;
          expect_hdr_next  = 1'b0;
          byte_pos_next    = 2'd0;
          partial_next     = '0;
        end
      end else if ({1'b0, byte_pos} + 3'd1 < bpp) begin
        partial_next  = partial | shifted[23:0];
        byte_pos_next = byte_pos + 2'd1;
        if (s_axis_tlast) begin
          failed_next     = 1'b1;
          res_valid       = 1'b1;
          res.final_pixel = 1'b1;
          res.status      = tgarle_pkg::STATUS_EARLY_END;
        end
      end else begin
        byte_pos_next = 2'd0;
        partial_next  = '0;
        if (rle_mode) begin
          if (is_run || pixels_left <= 8'd1) begin
            pixels_left_next = 8'd0;
            expect_hdr_next  = 1'b1;
          end else begin
            pixels_left_next = pixels_left - 8'd1;
          end
        end
        if (pix.alpha != tgarle_pkg::ALPHA_OPAQUE) begin
          opaque_next = 1'b0;
          if (pix.alpha != 8'd0) begin
            binary_alpha_next = 1'b0;
          end
        end
        res_valid        = 1'b1;
        res.pix          = pix;
        res.repeat_count = count;
        if (done_now) begin
          pixels_done_next = pixel_total;
          res.final_pixel  = 1'b1;
        end else begin
          pixels_done_next = done_sum[31:0];
          if (s_axis_tlast) begin
            failed_next     = 1'b1;
            res.final_pixel = 1'b1;
            res.status      = tgarle_pkg::STATUS_EARLY_END;
          end
        end
      end
    end

    res.image_opaque        = res.final_pixel && opaque_next;
    res.image_one_bit_alpha = res.final_pixel && binary_alpha_next;

    if (cfg_we) begin
      unique case (cfg_index)
        tgarle_pkg::REG_RLE_MODE: begin
          rle_mode_next    = cfg_data[0];
          expect_hdr_next  = 1'b1;
          byte_pos_next    = 2'd0;
          pixels_left_next = 8'd0;
          is_run_next      = 1'b0;
        end
        tgarle_pkg::REG_PIXEL_BYTES: begin
          pixel_bytes_count_next = cfg_data[2:0];
        end
        tgarle_pkg::REG_PIXEL_TOTAL: begin
          pixel_total_next = cfg_data[31:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rle_mode          <= tgarle_pkg::RLE_MODE_RESET;
      pixel_bytes_count <= tgarle_pkg::PIXEL_BYTES_RESET;
      pixel_total       <= tgarle_pkg::PIXEL_TOTAL_RESET;
      expect_hdr        <= 1'b1;
      is_run            <= 1'b0;
      pixels_left       <= 8'd0;
      byte_pos          <= 2'd0;
      partial           <= '0;
      pixels_done       <= '0;
      failed            <= 1'b0;
      opaque            <= 1'b1;
      binary_alpha      <= 1'b1;
      out_valid         <= 1'b0;
    end else begin
      rle_mode          <= rle_mode_next;
      pixel_bytes_count <= pixel_bytes_count_next;
      pixel_total       <= pixel_total_next;
      expect_hdr        <= expect_hdr_next;
      is_run            <= is_run_next;
      pixels_left       <= pixels_left_next;
      byte_pos          <= byte_pos_next;
      partial           <= partial_next;
      pixels_done       <= pixels_done_next;
      failed            <= failed_next;
      opaque            <= opaque_next;
      binary_alpha      <= binary_alpha_next;
      if (res_valid) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload register, loaded only when a new result is made
  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_res.repeat_count, out_res.pix.alpha, out_res.pix.blue,
                          out_res.pix.green, out_res.pix.red};
  assign m_axis_tlast  = out_res.final_pixel;
  assign m_axis_tuser  = {out_res.image_one_bit_alpha, out_res.image_opaque,
                          out_res.status};

  // an error status always ends the image
  `TGARLE_ASSERT_SAME(a_err_is_final, clk, rst,
    out_valid && out_res.status != tgarle_pkg::STATUS_OK, out_res.final_pixel)
  // a status-only transfer is always final
  `TGARLE_ASSERT_SAME(a_zero_count_final, clk, rst,
    out_valid && out_res.repeat_count == 8'd0, out_res.final_pixel)
  // once a final result is made the decoder stops taking part
  `TGARLE_ASSERT_NEXT(a_final_stops, clk, rst,
    res_valid && res.final_pixel && !cfg_we, !active)

endmodule

### dv/tga_rle_pixel_decoder_checker.sv
// checker for the tga rle pixel decoder: predicts results from observed transfers and compares
`timescale 1ns / 100ps

module tga_rle_pixel_decoder_checker
  import tgarle_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  input  logic        s_axis_tlast,   // end_of_file
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // red[7:0], green[15:8], blue[23:16], alpha[31:24], repeat_count[39:32]
  input  logic [39:0] m_axis_tdata,
  input  logic        m_axis_tlast,   // final_pixel
  // status[1:0], image_opaque[2], image_one_bit_alpha[3]
  input  logic [3:0]  m_axis_tuser,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data,
  output int          errors,
  output int          pending,
  output int          checked
);

  // register copies
  logic        rle_on;
  logic [2:0]  bpp_reg;
  logic [31:0] total;

  // decoder state
  logic        hdr_due;
  logic        in_run;
  logic [7:0]  left;
  logic [1:0]  bpos;
  logic [23:0] part;
  logic [31:0] done;
  logic        dead;
  logic        all_opaque;
  logic        all_binary;

  result_t pixels_due_q[$];

  function automatic logic [7:0] stretch5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic string show(input result_t r);
    return $sformatf("rgba %02x %02x %02x %02x count %0d last %0b status %0d opaque %0b onebit %0b",
                     r.pix.red, r.pix.green, r.pix.blue, r.pix.alpha, r.repeat_count,
                     r.final_pixel, r.status, r.image_opaque, r.image_one_bit_alpha);
  endfunction

  function automatic void push_pixel(input pixel_t p, input logic [7:0] cnt, input logic fin,
                                     input status_t st);
    result_t r;
    r.pix                 = p;
    r.repeat_count        = cnt;
    r.final_pixel         = fin;
    r.status              = st;
    r.image_opaque        = fin & all_opaque;
    r.image_one_bit_alpha = fin & all_binary;
    pixels_due_q.push_back(r);
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic eof);
    logic [2:0]  n;
    logic [7:0]  len;
    logic [7:0]  cnt;
    logic [15:0] word;
    pixel_t      p;
    if (dead || done >= total) return;
    n = (bpp_reg < BPP_MIN) ? BPP_MIN : (bpp_reg > BPP_MAX) ? BPP_MAX : bpp_reg;

    if (rle_on && hdr_due) begin
      len = {1'b0, b[6:0]} + 8'd1;
      if (eof) begin
        dead = 1'b1;
        push_pixel('0, 8'd0, 1'b1, STATUS_EARLY_END);
        return;
      end
      if ({1'b0, done} + 33'(len) > {1'b0, total}) begin
        dead = 1'b1;
        push_pixel('0, 8'd0, 1'b1, STATUS_OVERRUN);
        return;
      end
      in_run  = b[RunFlagBit];
      left    = len;
      hdr_due = 1'b0;
      bpos    = '0;
      part    = '0;
      return;
    end

    if (({1'b0, bpos} + 3'd1) < n) begin
      part = part | (24'(b) << (8 * bpos));
      bpos = bpos + 2'd1;
      if (eof) begin
        dead = 1'b1;
        push_pixel('0, 8'd0, 1'b1, STATUS_EARLY_END);
      end
      return;
    end

    // stored order is blue, green, red, alpha
    if (n == BPP_MIN) begin
      word    = {b, part[7:0]};
      p.red   = stretch5(word[14:10]);
      p.green = stretch5(word[9:5]);
      p.blue  = stretch5(word[4:0]);
      p.alpha = ALPHA_OPAQUE;
    end else if (n == BPP_MID) begin
      p.blue  = part[7:0];
      p.green = part[15:8];
      p.red   = b;
      p.alpha = ALPHA_OPAQUE;
    end else begin
      p.blue  = part[7:0];
      p.green = part[15:8];
      p.red   = part[23:16];
      p.alpha = b;
    end
    bpos = '0;
    part = '0;

    cnt = 8'd1;
    if (rle_on) begin
      if (in_run) begin
        cnt     = (left == 8'd0) ? 8'd1 : left;
        left    = '0;
        hdr_due = 1'b1;
      end else if (left <= 8'd1) begin
        left    = '0;
        hdr_due = 1'b1;
      end else begin
        left = left - 8'd1;
      end
    end

    if (p.alpha != ALPHA_OPAQUE) begin
      all_opaque = 1'b0;
      if (p.alpha != 8'h00) all_binary = 1'b0;
    end

    if ({1'b0, done} + 33'(cnt) >= {1'b0, total}) begin
      done = total;
      push_pixel(p, cnt, 1'b1, STATUS_OK);
    end else begin
      done = done + 32'(cnt);
      if (eof) begin
        dead = 1'b1;
        push_pixel(p, cnt, 1'b1, STATUS_EARLY_END);
      end else begin
        push_pixel(p, cnt, 1'b0, STATUS_OK);
      end
    end
  endtask

  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (rst) begin
      rle_on     = RLE_MODE_RESET;
      bpp_reg    = PIXEL_BYTES_RESET;
      total      = PIXEL_TOTAL_RESET;
      hdr_due    = 1'b1;
      in_run     = 1'b0;
      left       = '0;
      bpos       = '0;
      part       = '0;
      done       = '0;
      dead       = 1'b0;
      all_opaque = 1'b1;
      all_binary = 1'b1;
      pixels_due_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen.pix.red             = m_axis_tdata[7:0];
        seen.pix.green           = m_axis_tdata[15:8];
        seen.pix.blue            = m_axis_tdata[23:16];
        seen.pix.alpha           = m_axis_tdata[31:24];
        seen.repeat_count        = m_axis_tdata[39:32];
        seen.final_pixel         = m_axis_tlast;
        seen.status              = status_t'(m_axis_tuser[1:0]);
        seen.image_opaque        = m_axis_tuser[2];
        seen.image_one_bit_alpha = m_axis_tuser[3];
        if (pixels_due_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result with nothing outstanding: %s", $time, show(seen));
        end else begin
          want = pixels_due_q.pop_front();
          checked++;
          if (seen !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: mismatch, expected %s", $time, show(want));
              $display("%0t:           actual   %s", $time, show(seen));
            end
          end
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_RLE_MODE: begin
            rle_on  = cfg_data[0];
            hdr_due = 1'b1;
            bpos    = '0;
            left    = '0;
            in_run  = 1'b0;
          end
          REG_PIXEL_BYTES: bpp_reg = cfg_data[2:0];
          REG_PIXEL_TOTAL: total = cfg_data[31:0];
          default: ;
        endcase
      end

      if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata, s_axis_tlast);
    end
    pending = pixels_due_q.size();
  end

endmodule

### dv/tb.sv
// testbench top for the tga rle pixel decoder: clock, reset, byte stimulus and verdict
`timescale 1ns / 100ps

module tb;
  import tgarle_pkg::*;

  localparam logic [31:0] TOTAL_MAX = 32'd4294836225;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;     // data_byte[7:0]
  logic        s_axis_tlast = 1'b0;   // end_of_file
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;          // red, green, blue, alpha, repeat_count from bit 0
  logic        m_axis_tlast;          // final_pixel
  logic [3:0]  m_axis_tuser;          // status[1:0], image_opaque, image_one_bit_alpha
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_RLE_MODE;
  logic [CfgDataWidth-1:0] cfg_data = '0;

  int errors;
  int pending;
  int checked;

  int src_gap_pct   = 15;
  int dst_stall_pct = 68;
  int sent          = 0;
  int stray         = 0;
  int images        = 0;
  int closing_case  = 0;
  logic [31:0] base = '0;   // pixels already decoded, equal to the last finished total

  always #5 clk = ~clk;

  tga_rle_pixel_decoder_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  tga_rle_pixel_decoder_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (errors),
    .pending       (pending),
    .checked       (checked)
  );

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= dst_stall_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // valid stays high between back-to-back transfers
  task automatic send_byte(input logic [7:0] d, input logic eof);
    while ($urandom_range(99) < src_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tlast  <= eof;
    do @(posedge clk); while (!s_axis_tready);
    sent++;
  endtask

  task automatic send_stray(input int k);
    repeat (k) begin
      send_byte(8'($urandom), 1'($urandom));
      stray++;
    end
  endtask

  // hold the sender until every outstanding result has been taken
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_regs(input logic mode, input logic [2:0] bpp, input logic [31:0] tot);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_RLE_MODE;
    cfg_data  <= CfgDataWidth'(mode);
    @(posedge clk);
    cfg_index <= REG_PIXEL_BYTES;
    cfg_data  <= CfgDataWidth'(bpp);
    @(posedge clk);
    cfg_index <= REG_PIXEL_TOTAL;
    cfg_data  <= tot;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic write_total(input logic [31:0] tot);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_PIXEL_TOTAL;
    cfg_data  <= tot;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // alpha_kind: 0 opaque only, 1 zero or opaque, 2 anything
  task automatic send_pixel(input int n, input int alpha_kind, input logic last_px, input logic eof_ok);
    logic [7:0] d;
    int pick;
    for (int k = 0; k < n; k++) begin
      d = 8'($urandom);
      if (n == 4 && k == 3) begin
        pick = $urandom_range(3);
        if (alpha_kind == 0) d = ALPHA_OPAQUE;
        else if (alpha_kind == 1 || pick < 2) d = pick[0] ? ALPHA_OPAQUE : 8'h00;
      end
      send_byte(d, last_px && eof_ok && k == n - 1 && $urandom_range(1));
    end
  endtask

  task automatic decode_image(input logic mode, input logic [2:0] bpp, input int npix,
                              input int alpha_kind);
    int n;
    int rem;
    int len;
    int cap;
    logic run;
    n = (bpp < BPP_MIN) ? 2 : (bpp > BPP_MAX) ? 4 : int'(bpp);
    write_regs(mode, bpp, base + 32'(npix));
    rem = npix;
    while (rem > 0) begin
      if (mode) begin
        run = 1'($urandom);
        cap = run ? ((rem < 128) ? rem : 128) : ((rem < 6) ? rem : 6);
        len = ($urandom_range(3) == 0) ? cap : $urandom_range(cap, 1);
        send_byte({run, 7'(len - 1)}, 1'b0);
        if (run) begin
          send_pixel(n, alpha_kind, rem == len, 1'b1);
        end else begin
          for (int i = 0; i < len; i++) send_pixel(n, alpha_kind, rem - i == 1, 1'b1);
        end
        rem -= len;
      end else begin
        send_pixel(n, alpha_kind, rem == 1, 1'b1);
        rem--;
      end
    end
    base += 32'(npix);
    images++;
  endtask

  initial begin
    logic       mode;
    logic [2:0] bpp;
    int         r;
    int         npix;
    int         useful;
    int         k;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // registers at their reset values: one raw packet of one opaque pixel
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(ALPHA_OPAQUE, 1'b0);
    base = 32'd1;
    images++;

    // uncompressed 3-byte pixels, all ones then all zeros, end of file on the last byte
    write_regs(1'b0, BPP_MID, base + 32'd2);
    repeat (3) send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    base += 32'd2;
    images++;

    // longest run of a 5-5-5 pixel
    write_regs(1'b1, BPP_MIN, base + 32'd128);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    base += 32'd128;
    images++;

    // raw packet then a one-pixel run, alpha only zero or opaque
    write_regs(1'b1, BPP_MAX, base + 32'd3);
    send_byte(8'h01, 1'b0);
    send_byte(8'h10, 1'b0); send_byte(8'h20, 1'b0); send_byte(8'h30, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h40, 1'b0); send_byte(8'h50, 1'b0); send_byte(8'h60, 1'b0);
    send_byte(ALPHA_OPAQUE, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h70, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h90, 1'b0);
    send_byte(8'h00, 1'b1);
    base += 32'd3;
    images++;

    useful = sent - stray;
    while (useful < 950) begin
      if (useful < 317) begin
        src_gap_pct = 15; dst_stall_pct = 68;
      end else if (useful < 634) begin
        src_gap_pct = 68; dst_stall_pct = 15;
      end else begin
        src_gap_pct = 0; dst_stall_pct = 0;
      end

      mode = 1'($urandom);
      r = $urandom_range(9);
      if (r < 8) bpp = 3'(2 + r % 3);
      else if (r == 8) bpp = 3'($urandom_range(1, 0));
      else bpp = 3'($urandom_range(7, 5));
      if (mode && $urandom_range(5) == 0) npix = $urandom_range(300, 100);
      else npix = $urandom_range(mode ? 10 : 8, 1);
      decode_image(mode, bpp, npix, 2);

      // the finished image ignores anything more
      if ($urandom_range(3) == 0) send_stray($urandom_range(3, 1));
      // a total at or below the pixel count also leaves the image finished
      if ($urandom_range(9) == 0) begin
        write_total($urandom_range(1) ? 32'd0 : base);
        send_stray($urandom_range(3, 1));
      end
      useful = sent - stray;
    end

    // an error is sticky, so exactly one error case closes the run
    closing_case = $urandom_range(3);
    case (closing_case)
      0: begin
        write_regs(1'b1, BPP_MID, base + 32'd3);
        send_byte(8'h01, 1'b0);
        send_pixel(3, 2, 1'b0, 1'b0);
        send_pixel(3, 2, 1'b0, 1'b0);
        send_byte(8'h81, 1'b0);
      end
      1: begin
        write_regs(1'b1, BPP_MIN, TOTAL_MAX);
        send_byte(8'($urandom), 1'b1);
      end
      2: begin
        write_regs(1'b0, BPP_MAX, TOTAL_MAX);
        send_pixel(4, 2, 1'b0, 1'b0);
        send_byte(8'($urandom), 1'b0);
        send_byte(8'($urandom), 1'b1);
      end
      default: begin
        write_regs(1'b1, BPP_MAX, TOTAL_MAX);
        send_byte(8'h02, 1'b0);
        send_pixel(4, 2, 1'b0, 1'b0);
        send_pixel(3, 2, 1'b0, 1'b0);
        send_byte(8'($urandom), 1'b1);
      end
    endcase
    send_stray(3);
    s_axis_tvalid <= 1'b0;

    k = 0;
    while (pending != 0 && k < 200000) begin
      @(posedge clk);
      k++;
    end
    repeat (20) @(posedge clk);

    $display("covered %0d data bytes over %0d images, %0d ignored bytes, %0d results checked",
             sent - stray, images, stray, checked);
    $display("closing error case %0d (0 overrun, 1 end on header, 2 end mid pixel, 3 end on pixel)",
             closing_case);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### tga_rle_pixel_decoder_core.f
+incdir+sv
sv/tgarle_pkg.sv
sv/tgarle_pixel_unpack.sv
sv/tga_rle_pixel_decoder_core.sv
dv/tga_rle_pixel_decoder_checker.sv
dv/tb.sv
